>>> hw/rtl/tcop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcop_pkg: shared types and constants for the tile column opacity profiler
// Field widths, default tile edge and the control structs between the cells.
// ----------------------------------------------------------------------------
package tcop_pkg;

   localparam int TILE_EDGE_DEFAULT   = 32;
   localparam int PIXEL_W             = 8;
   localparam int COLUMN_W            = 5;
   localparam int TOP_GAP_W           = 5;
   localparam int BOTTOM_GAP_W        = 6;
   localparam logic [PIXEL_W-1:0] TRANSPARENT_RESET = 8'd255;

   // control for the column state chain
   typedef struct packed {
      logic advance;   // rotate the chain by one column
      logic clear;     // tile done, start a fresh tile
   } col_ctl_type;

   // control for the result chain
   typedef struct packed {
      logic load;      // capture a whole tile of results
      logic advance;   // one result item taken
   } out_ctl_type;

   typedef struct packed {
      logic [TOP_GAP_W-1:0]    top_gap;
      logic [BOTTOM_GAP_W-1:0] bottom_gap;
   } result_type;

endpackage

>>> hw/rtl/tcop_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcop_col_cell: one column's opacity state
// Takes its neighbor's state on advance, applying an opaque hit at the row.
// ----------------------------------------------------------------------------
module tcop_col_cell #(
   parameter int RowW = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  tcop_pkg::col_ctl_type ctl,
   input  logic                hit,
   input  logic [RowW-1:0]     row,
   input  logic                nbr_seen,
   input  logic [RowW-1:0]     nbr_first,
   input  logic [RowW-1:0]     nbr_last,
   output logic                seen,
   output logic [RowW-1:0]     first,
   output logic [RowW-1:0]     last,
   output logic                seen_d,
   output logic [RowW-1:0]     first_d,
   output logic [RowW-1:0]     last_d
);

   logic            seen_ff;
   logic [RowW-1:0] first_ff;
   logic [RowW-1:0] last_ff;

   always_comb begin
      seen_d  = nbr_seen | hit;
      first_d = (hit && !nbr_seen) ? row : nbr_first;
      last_d  = hit ? row : nbr_last;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         seen_ff  <= 1'b0;
         first_ff <= '0;
         last_ff  <= '0;
      end else if (ctl.advance) begin
         seen_ff  <= seen_d;
         first_ff <= first_d;
         last_ff  <= last_d;
      end
   end

   assign seen  = seen_ff;
   assign first = first_ff;
   assign last  = last_ff;

endmodule

>>> hw/rtl/tcop_out_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcop_out_cell: one stage of the result shift chain
// Loads a finished column result, then shifts toward the output head.
// ----------------------------------------------------------------------------
module tcop_out_cell (
   input  logic                 clock,
   input  tcop_pkg::out_ctl_type ctl,
   input  tcop_pkg::result_type load_value,
   input  tcop_pkg::result_type nbr_value,
   output tcop_pkg::result_type value
);

   tcop_pkg::result_type value_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         value_ff <= load_value;
      end else if (ctl.advance) begin
         value_ff <= nbr_value;
      end
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/tile_column_opacity_profile_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_column_opacity_profile_unit: per-column opacity gaps of a square tile
// Scans tile pixels row-major and emits one gap result per column per tile.
// ----------------------------------------------------------------------------
// Takes one pixel item per cycle, TILE_EDGE*TILE_EDGE pixels per tile in
// row-major order. A ring of TILE_EDGE column cells rotates by one on every
// pixel, so the cell at the head always holds the current column; after a
// full row the ring is back in column order. On the final pixel of a tile the
// ring's contents are turned into results and loaded all at once into a
// separate result chain, and the ring is cleared. The result chain then
// shifts out TILE_EDGE result items, column 0 first, one per cycle while
// rsp_ready is high, while the next tile's pixels keep flowing in. The only
// stall: the final pixel of a tile is held off until the previous tile's
// last result is taken (taking it in that same cycle is enough). Sustained
// rate is one pixel per cycle as long as each tile's TILE_EDGE results are
// all taken by the time the next tile's final pixel arrives. The transparent
// index resets to 255 and applies to pixels accepted after the write.
// ----------------------------------------------------------------------------
module tile_column_opacity_profile_unit #(
   parameter int TILE_EDGE = tcop_pkg::TILE_EDGE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcop_pkg::PIXEL_W-1:0]      csr_data,
   // pixel items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tcop_pkg::PIXEL_W-1:0]      req_pixel,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcop_pkg::COLUMN_W-1:0]     rsp_column,
   output logic [tcop_pkg::TOP_GAP_W-1:0]    rsp_top_gap,
   output logic [tcop_pkg::BOTTOM_GAP_W-1:0] rsp_bottom_gap,
   output logic                              rsp_last_column
);

   localparam int RowW = $clog2(TILE_EDGE);
   localparam logic [RowW-1:0] EdgeM1 = RowW'(TILE_EDGE - 1);
   localparam logic [RowW:0]   EdgeM1W = (RowW + 1)'(TILE_EDGE - 1);
   localparam logic [RowW:0]   EdgeW   = (RowW + 1)'(TILE_EDGE);

   // config register
   logic [tcop_pkg::PIXEL_W-1:0] transparent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_ff <= tcop_pkg::TRANSPARENT_RESET;
      end else if (csr_valid) begin
         transparent_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // pixel position as column and row counters
   logic [RowW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic            tile_last;
   logic            req_fire;
   logic            rsp_fire;
   logic            hit;

   // result side status
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RowW-1:0] out_col_ff, out_col_in;
   logic            out_draining;   // last result leaves this cycle

   assign tile_last    = (col_ff == EdgeM1) && (row_ff == EdgeM1);
   assign rsp_fire     = rsp_valid_ff && rsp_ready;
   assign out_draining = rsp_fire && (out_col_ff == EdgeM1);
   assign req_ready    = !(tile_last && rsp_valid_ff && !out_draining);
   assign req_fire     = req_valid && req_ready;
   assign hit          = req_fire && (req_pixel != transparent_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_ff == EdgeM1) begin
            col_in = '0;
            row_in = (row_ff == EdgeM1) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // column ring: cell 0 is the head, tail takes the updated head
   tcop_pkg::col_ctl_type col_ctl;
   assign col_ctl.advance = req_fire;
   assign col_ctl.clear   = req_fire && tile_last;

   logic            seen_q  [TILE_EDGE];
   logic [RowW-1:0] first_q [TILE_EDGE];
   logic [RowW-1:0] last_q  [TILE_EDGE];
   logic            seen_d  [TILE_EDGE];
   logic [RowW-1:0] first_d [TILE_EDGE];
   logic [RowW-1:0] last_d  [TILE_EDGE];

   tcop_pkg::result_type res_load [TILE_EDGE];
   tcop_pkg::result_type res_q    [TILE_EDGE];

   tcop_pkg::out_ctl_type out_ctl;
   assign out_ctl.load    = col_ctl.clear;
   assign out_ctl.advance = rsp_fire;

   for (genvar j = 0; j < TILE_EDGE; j++) begin : g_col
      localparam int Nbr = (j == TILE_EDGE - 1) ? 0 : j + 1;
      logic            top_w;
      logic [RowW-1:0] top_row;
      logic [RowW:0]   bottom_row;

      tcop_col_cell #(.RowW(RowW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (col_ctl),
         .hit       ((j == TILE_EDGE - 1) ? hit : 1'b0),
         .row       (row_ff),
         .nbr_seen  (seen_q[Nbr]),
         .nbr_first (first_q[Nbr]),
         .nbr_last  (last_q[Nbr]),
         .seen      (seen_q[j]),
         .first     (first_q[j]),
         .last      (last_q[j]),
         .seen_d    (seen_d[j]),
         .first_d   (first_d[j]),
         .last_d    (last_d[j])
      );

      // after the final rotation seen_d[j] etc. hold column j in order
      assign top_w      = seen_d[j];
      assign top_row    = top_w ? first_d[j] : EdgeM1;
      assign bottom_row = top_w ? (EdgeM1W - {1'b0, last_d[j]}) : EdgeW;
      assign res_load[j].top_gap    = tcop_pkg::TOP_GAP_W'(top_row);
      assign res_load[j].bottom_gap = tcop_pkg::BOTTOM_GAP_W'(bottom_row);

      tcop_out_cell u_out (
         .clock      (clock),
         .ctl        (out_ctl),
         .load_value (res_load[j]),
         .nbr_value  ((j == TILE_EDGE - 1) ? res_q[j] : res_q[Nbr]),
         .value      (res_q[j])
      );
   end

   // result sequencing
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_col_in   = out_col_ff;
      if (out_ctl.load) begin
         rsp_valid_in = 1'b1;
         out_col_in   = '0;
      end else if (rsp_fire) begin
         if (out_col_ff == EdgeM1) begin
            rsp_valid_in = 1'b0;
         end
         out_col_in = out_col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_col_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         out_col_ff   <= out_col_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = tcop_pkg::COLUMN_W'(out_col_ff);
   assign rsp_top_gap     = res_q[0].top_gap;
   assign rsp_bottom_gap  = res_q[0].bottom_gap;
   assign rsp_last_column = rsp_valid_ff && (out_col_ff == EdgeM1);

`ifndef SYNTHESIS
   // a tile's results start at column 0 right after its final pixel
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && tile_last) |=> (rsp_valid && out_col_ff == '0))
      else $error("result burst did not start at column 0");

   // results stop only after the final column went out
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_last_column && rsp_ready))
      else $error("result burst ended early");

   // pixel position is back at the tile start after the final pixel
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && tile_last) |=> (col_ff == '0 && row_ff == '0))
      else $error("pixel position did not wrap at tile end");
`endif

endmodule
